[hdl/pon_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the probe overlap and neighbour check.
package pon_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int RADIUS_W    = 10;
    localparam int CELL_SIZE_W = 16;
    localparam int DIAM_W      = 11;
    localparam int CUTOFF_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // cell size is never below 256, so a cell index needs 8 bits fewer than a coordinate
    localparam int CELL_SHIFT = 8;
    localparam int CELL_W     = COORD_WIDTH - CELL_SHIFT;
    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int REACH_W    = DIAM_W + 1;
    localparam int D2_W       = 2 * DIFF_W + 2;

    localparam logic [CELL_SIZE_W-1:0] CELL_MIN = CELL_SIZE_W'(256);

    localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RESET = CELL_SIZE_W'(2560);
    localparam logic [DIAM_W-1:0]      DIAM_RESET      = DIAM_W'(717);
    localparam logic [CUTOFF_W-1:0]    CUTOFF_RESET    = CUTOFF_W'(896);

    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_ATOM   = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CELL_SIZE      = 2'd0,
        REG_PROBE_DIAMETER = 2'd1,
        REG_CUTOFF         = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                          op;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic [RADIUS_W-1:0]           atom_radius;
        logic                          last_atom;
    } item_t;

    typedef struct packed {
        logic placement_ok;
        logic collided;
        logic has_neighbor;
    } result_t;

endpackage

[hdl/probe_overlap_neighbor_check.sv]
`timescale 1ns / 1ps
// Top level: probe placement check against a stream of candidate atoms.
//
//  channel  | handshake                     | word
//  ---------+-------------------------------+--------------------------------
//  item     | item_valid / item_stall       | item_t: op, position, radius, last
//  result   | result_valid / result_stall   | result_t: ok, collided, neighbour
//  cfg      | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// Each item goes through these steps from accept to the next accept: the bit-serial squarers
// of the axis differences run with the three cell dividers alongside, RUN sees them all idle,
// SUM sums the squares and tests the cells, FIN compares and updates the flags (a last item
// waits there while a held result is stalled), and IDLE accepts the next word.
// One item is in work at a time; item_stall is high from accept until it completes.
// A finished result waits in the output register; a stalled result holds only the last item.
// Reset restores the configuration defaults, the target at the origin in cell zero and
// clear flags.
module probe_overlap_neighbor_check
    import pon_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MAG_W = COORD_WIDTH - 1;
    localparam logic [CELL_W:0] DC_ONE       = (CELL_W+1)'(1);
    localparam logic [CELL_W:0] DC_MINUS_ONE = {(CELL_W+1){1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CELL_SIZE_W-1:0] cell_size_reg;
    logic [DIAM_W-1:0]      probe_diameter_reg;
    logic [CUTOFF_W-1:0]    cutoff_reg;

    logic signed [COORD_WIDTH-1:0] tpos_reg [3];
    logic [CELL_W-1:0]             tcell_reg [3];
    logic                          collision_reg;
    logic                          neighbor_reg;
    logic                          op_reg;
    logic                          last_reg;
    logic [2:0]                    sign_reg;
    logic                          near_reg;
    logic [D2_W-1:0]               d2_reg;
    logic                          result_valid_reg;
    result_t                       result_reg;

    logic signed [COORD_WIDTH-1:0] pos [3];
    logic [MAG_W-1:0]              dividend [3];
    logic [DIFF_W-1:0]             mag [3];
    logic [MAG_W-1:0]              quo [3];
    logic [CELL_W-1:0]             cell_idx [3];
    logic [2*DIFF_W-1:0]           sq [3];
    logic [2:0]                    div_busy;
    logic [2:0]                    sqr_busy;
    logic [2:0]                    axis_near;

    logic                          start;
    logic                          any_busy;
    logic [CELL_SIZE_W-1:0]        cell_eff;
    logic [REACH_W-1:0]            reach;
    logic [2*REACH_W-1:0]          reach2;
    logic [2*CUTOFF_W-1:0]         cut2;
    logic                          reach_busy;
    logic                          cut_busy;
    logic [D2_W-1:0]               d2_sum;
    logic                          coll_hit;
    logic                          nb_hit;
    logic                          coll_new;
    logic                          nb_new;
    logic                          out_free;
    logic                          fin_go;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != ST_IDLE);
    assign start        = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign pos[0] = item.pos_x;
    assign pos[1] = item.pos_y;
    assign pos[2] = item.pos_z;

    assign cell_eff = (cell_size_reg < CELL_MIN) ? CELL_MIN : cell_size_reg;

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_axis
            logic [DIFF_W-1:0] fwd;
            logic [DIFF_W-1:0] rev;
            logic [CELL_W:0]   dc;

            // floor of a negative p is the complement of floor(~p / c)
            assign dividend[a] = pos[a][COORD_WIDTH-1] ? ~pos[a][MAG_W-1:0]
                                                       : pos[a][MAG_W-1:0];

            // magnitude stays within 2^COORD_WIDTH, so it fits in DIFF_W bits
            assign fwd    = {tpos_reg[a][COORD_WIDTH-1], tpos_reg[a]}
                          - {pos[a][COORD_WIDTH-1], pos[a]};
            assign rev    = {pos[a][COORD_WIDTH-1], pos[a]}
                          - {tpos_reg[a][COORD_WIDTH-1], tpos_reg[a]};
            assign mag[a] = fwd[DIFF_W-1] ? rev : fwd;

            pon_div #(
                .DIVIDEND_W (MAG_W),
                .DIVISOR_W  (CELL_SIZE_W)
            ) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (start),
                .dividend (dividend[a]),
                .divisor  (cell_eff),
                .busy     (div_busy[a]),
                .quotient (quo[a])
            );

            pon_sqr #(
                .WIDTH (DIFF_W)
            ) u_sqr (
                .clk     (clk),
                .rst_n   (rst_n),
                .start   (start),
                .operand (mag[a]),
                .busy    (sqr_busy[a]),
                .square  (sq[a])
            );

            assign cell_idx[a] = sign_reg[a] ? ~{1'b0, quo[a][CELL_W-2:0]}
                                             : {1'b0, quo[a][CELL_W-2:0]};
            assign dc      = {cell_idx[a][CELL_W-1], cell_idx[a]}
                           - {tcell_reg[a][CELL_W-1], tcell_reg[a]};
            assign axis_near[a] = (dc == '0) || (dc == DC_ONE) || (dc == DC_MINUS_ONE);
        end
    endgenerate

    assign reach = {1'b0, probe_diameter_reg} + {1'b0, item.atom_radius, 1'b0};

    pon_sqr #(
        .WIDTH (REACH_W)
    ) u_sqr_reach (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (reach),
        .busy    (reach_busy),
        .square  (reach2)
    );

    pon_sqr #(
        .WIDTH (CUTOFF_W)
    ) u_sqr_cut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (cutoff_reg),
        .busy    (cut_busy),
        .square  (cut2)
    );

    assign any_busy = (|div_busy) || (|sqr_busy) || reach_busy || cut_busy;

    assign d2_sum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

    // collision compares 4*d2 with (diameter + 2*radius)^2, so no halving is needed
    assign coll_hit = near_reg
                   && ({d2_reg, 2'b00} <= {{(D2_W+2-2*REACH_W){1'b0}}, reach2});
    assign nb_hit   = near_reg && (d2_reg <= {{(D2_W-2*CUTOFF_W){1'b0}}, cut2});

    // a target word clears both flags
    assign coll_new = (op_reg == OP_ATOM) ? (collision_reg || coll_hit) : 1'b0;
    assign nb_new   = (op_reg == OP_ATOM) ? (neighbor_reg || nb_hit) : 1'b0;

    assign out_free = !result_valid_reg || !result_stall;
    assign fin_go   = (state_reg == ST_FIN) && (!last_reg || out_free);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!any_busy)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cell_size_reg      <= CELL_SIZE_RESET;
            probe_diameter_reg <= DIAM_RESET;
            cutoff_reg         <= CUTOFF_RESET;
            for (int i = 0; i < 3; i++)
            begin
                tpos_reg[i]  <= '0;
                tcell_reg[i] <= '0;
            end
            collision_reg    <= 1'b0;
            neighbor_reg     <= 1'b0;
            op_reg           <= OP_TARGET;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CELL_SIZE:      cell_size_reg      <= cfg_data[CELL_SIZE_W-1:0];
                    REG_PROBE_DIAMETER: probe_diameter_reg <= cfg_data[DIAM_W-1:0];
                    REG_CUTOFF:         cutoff_reg         <= cfg_data[CUTOFF_W-1:0];
                    default:            ;
                endcase
            end

            if (start)
            begin
                op_reg   <= item.op;
                last_reg <= item.last_atom;
                if (item.op == OP_TARGET)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        tpos_reg[i] <= pos[i];
                    end
                end
            end

            if (fin_go)
            begin
                collision_reg <= last_reg ? 1'b0 : coll_new;
                neighbor_reg  <= last_reg ? 1'b0 : nb_new;
                if (op_reg == OP_TARGET)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        tcell_reg[i] <= cell_idx[i];
                    end
                end
            end

            if (fin_go && last_reg)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sign_reg <= {pos[2][COORD_WIDTH-1], pos[1][COORD_WIDTH-1], pos[0][COORD_WIDTH-1]};
        end
        if (state_reg == ST_SUM)
        begin
            d2_reg   <= d2_sum;
            near_reg <= &axis_near;
        end
        if (fin_go && last_reg)
        begin
            result_reg.placement_ok <= !coll_new && nb_new;
            result_reg.collided     <= coll_new;
            result_reg.has_neighbor <= nb_new;
        end
    end

endmodule

[hdl/pon_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module pon_div #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  fits;

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg;

    // bring down the next dividend bit and try the subtract
    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign fits      = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            count_next = CNT_W'(DIVIDEND_W);
            rem_next   = '0;
            quo_next   = dividend;
        end
        else if (busy)
        begin
            count_next = count_reg - CNT_W'(1);
            rem_next   = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

endmodule

[hdl/pon_sqr.sv]
`timescale 1ns / 1ps
// Shift-and-add squarer, one multiplier bit per cycle.
module pon_sqr #(
    parameter int WIDTH = 21
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   operand,
    output logic               busy,
    output logic [2*WIDTH-1:0] square
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [WIDTH-1:0]     mcand_reg;
    logic [2*WIDTH-1:0]   prod_reg;
    logic [2*WIDTH-1:0]   prod_next;
    logic [WIDTH:0]       upper_sum;

    assign busy   = (count_reg != '0);
    assign square = prod_reg;

    // add into the upper half, then shift the whole product right
    assign upper_sum = {1'b0, prod_reg[2*WIDTH-1:WIDTH]}
                     + (prod_reg[0] ? {1'b0, mcand_reg} : {(WIDTH+1){1'b0}});

    always_comb
    begin
        count_next = count_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            count_next = CNT_W'(WIDTH);
            prod_next  = {{WIDTH{1'b0}}, operand};
        end
        else if (busy)
        begin
            count_next = count_reg - CNT_W'(1);
            prod_next  = {upper_sum, prod_reg[WIDTH-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (start)
        begin
            mcand_reg <= operand;
        end
    end

endmodule
